>>> sv/dpf_pkg.sv
// ============================================================================
// dpf_pkg: shared types and constants for the deduplicating packet FIFO
// Item and result layouts, command codes and stored entry format.
// ============================================================================
package dpf_pkg;

	// Default number of packet slots
	localparam int DEPTH_DEFAULT = 64;

	// Reset value of the queue limit register
	localparam logic [6:0] LIMIT_RESET = 7'd64;

	// Largest value the match count field can show
	localparam logic [6:0] COUNT_MAX = 7'd127;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_FWD   = 2'd1,
		CMD_COUNT = 2'd2
	} cmd_t;

	// One stored packet
	typedef struct packed {
		logic [31:0] tstamp;
		logic [15:0] dst;
		logic [15:0] src;
	} entry_t;

	// One input item
	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] source_id;
		logic [15:0] destination_id;
		logic [31:0] arrival_time;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} item_t;

	// One result item
	typedef struct packed {
		logic        accepted;
		logic        packet_valid;
		logic [15:0] out_source;
		logic [15:0] out_destination;
		logic [31:0] out_time;
		logic [6:0]  match_count;
	} res_t;

	// Compare flags for one stored entry
	typedef struct packed {
		logic dup;
		logic hit;
	} match_t;

endpackage

>>> sv/dedup_packet_fifo_range_count.sv
// ============================================================================
// dedup_packet_fifo_range_count: bounded packet FIFO with dedup and counting
// Top level: stream ports, queue limit register and output register.
// ============================================================================
// Usage:
//   Slave stream carries one command item: tuser holds the command (add,
//   forward, count), tdata the packet fields and the count window. Master
//   stream returns exactly one result item per command.
//   Adds and counts read every queued packet from the packet store, one
//   slot per cycle on its single read port; a forward reads only the head.
//   The next item is taken only after the previous one has finished its
//   scan and passed its result on to the output register.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, the next finished result holds inside
//   until the register drains, and no further item is taken.
//   Reset empties the queue and sets the queue limit to 64. Write
//   cfg_wr_data with cfg_wr_en only while no item is in flight.
// ============================================================================
module dedup_packet_fifo_range_count #(
	parameter int QUEUE_DEPTH = dpf_pkg::DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	// Command items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// source_id, destination_id, arrival_time, range_start, range_end
	input  logic [127:0] s_axis_tdata,
	// command
	input  logic [1:0]   s_axis_tuser,
	// Result items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_source, out_destination, out_time, match_count, one zero pad bit
	output logic [71:0]  m_axis_tdata,
	// accepted, packet_valid
	output logic [1:0]   m_axis_tuser,
	// Queue limit register
	input  logic         cfg_wr_en,
	input  logic [6:0]   cfg_wr_data
);

	logic [6:0]     limit_q;
	dpf_pkg::item_t item;
	dpf_pkg::res_t  res;
	logic           res_valid;
	logic           res_ready;
	logic           out_v_q;
	dpf_pkg::res_t  out_q;

	// Unpack the command item
	assign item.command        = s_axis_tuser;
	assign item.source_id      = s_axis_tdata[15:0];
	assign item.destination_id = s_axis_tdata[31:16];
	assign item.arrival_time   = s_axis_tdata[63:32];
	assign item.range_start    = s_axis_tdata[95:64];
	assign item.range_end      = s_axis_tdata[127:96];

	// Hold the queue limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dpf_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	dpf_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.item        (item),
		.queue_limit (limit_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: load when empty or draining
	assign res_ready = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Pack the result item
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_q.match_count, out_q.out_time,
	                        out_q.out_destination, out_q.out_source};
	assign m_axis_tuser  = {out_q.packet_valid, out_q.accepted};

endmodule

>>> sv/dpf_ram.sv
// ============================================================================
// dpf_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
module dpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/dpf_match.sv
// ============================================================================
// dpf_match: per-entry compare unit
// Flags an exact duplicate of the item's packet and a destination/time hit.
// ============================================================================
module dpf_match (
	input  dpf_pkg::entry_t entry,
	input  dpf_pkg::item_t  item,
	output dpf_pkg::match_t flags
);

	// Duplicate: all three packet fields equal
	assign flags.dup = (entry.src == item.source_id) &&
	                   (entry.dst == item.destination_id) &&
	                   (entry.tstamp == item.arrival_time);

	// Range hit: same destination, time inside the inclusive window
	assign flags.hit = (entry.dst == item.destination_id) &&
	                   (entry.tstamp >= item.range_start) &&
	                   (entry.tstamp <= item.range_end);

endmodule

>>> sv/dpf_engine.sv
// ============================================================================
// dpf_engine: queue sequencer around the packet store
// Scans occupied slots one per cycle through the RAM read port, accumulates
// duplicate and range-match flags, then commits the queue update.
// ============================================================================
module dpf_engine #(
	parameter int QUEUE_DEPTH = dpf_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dpf_pkg::item_t  item,
	input  logic [6:0]      queue_limit,
	output logic            res_valid,
	input  logic            res_ready,
	output dpf_pkg::res_t   res
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = IW + 1;
	localparam int CW = (OW > 7) ? OW : 7;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   head_q;
	logic [OW-1:0]   occ_q;
	logic [OW-1:0]   k_q;
	logic [OW-1:0]   n_q;
	logic            rd_v_s1;
	dpf_pkg::item_t  item_q;
	logic            dup_q;
	logic [OW-1:0]   cnt_q;
	dpf_pkg::entry_t pkt_q;

	dpf_pkg::entry_t rdata;
	dpf_pkg::match_t flags;
	logic [OW-1:0]   scan_len;
	logic            issue;
	logic [SW-1:0]   rd_sum;
	logic [SW-1:0]   wr_sum;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	logic [IW-1:0]   head_inc;
	logic [CW-1:0]   lim_raw;
	logic [CW-1:0]   lim_one;
	logic [CW-1:0]   lim_eff;
	logic            at_limit;
	logic            commit;
	logic            add_ok;
	logic            fwd_ok;
	logic            ram_we;
	logic [CW-1:0]   cnt_ext;

	// Slot addresses wrap around the store
	assign rd_sum  = {1'b0, head_q} + SW'(k_q);
	assign wr_sum  = {1'b0, head_q} + SW'(occ_q);
	assign rd_addr = (rd_sum >= SW'(QUEUE_DEPTH)) ? IW'(rd_sum - SW'(QUEUE_DEPTH))
	                                              : rd_sum[IW-1:0];
	assign wr_addr = (wr_sum >= SW'(QUEUE_DEPTH)) ? IW'(wr_sum - SW'(QUEUE_DEPTH))
	                                              : wr_sum[IW-1:0];
	assign head_inc = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);

	// Clamp the limit into one to depth
	assign lim_raw  = CW'(queue_limit);
	assign lim_one  = (lim_raw == '0) ? CW'(1) : lim_raw;
	assign lim_eff  = (lim_one > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : lim_one;
	assign at_limit = CW'(occ_q) >= lim_eff;

	// Number of entries to read for the incoming command
	always_comb begin
		case (item.command)
			dpf_pkg::CMD_ADD,
			dpf_pkg::CMD_COUNT: scan_len = occ_q;
			dpf_pkg::CMD_FWD:   scan_len = (occ_q != '0) ? OW'(1) : '0;
			default:            scan_len = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign issue    = (state_q == ST_SCAN) && (k_q != n_q);
	assign commit   = (state_q == ST_DONE) && res_ready;
	assign add_ok   = (item_q.command == dpf_pkg::CMD_ADD) && !dup_q;
	assign fwd_ok   = (item_q.command == dpf_pkg::CMD_FWD) && (occ_q != '0);
	assign ram_we   = commit && add_ok;

	dpf_ram #(
		.WIDTH ($bits(dpf_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata ({item_q.arrival_time, item_q.destination_id, item_q.source_id}),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	dpf_match u_match (
		.entry (rdata),
		.item  (item_q),
		.flags (flags)
	);

	// Sequence scan and commit, update head and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			k_q     <= '0;
			n_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (in_valid) begin
						state_q <= ST_SCAN;
						k_q     <= '0;
						n_q     <= scan_len;
					end
				end
				ST_SCAN: begin
					rd_v_s1 <= issue;
					if (issue) begin
						k_q <= k_q + OW'(1);
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_v_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= ST_IDLE;
						if (add_ok) begin
							if (at_limit) begin
								head_q <= head_inc;
							end else begin
								occ_q <= occ_q + OW'(1);
							end
						end else if (fwd_ok) begin
							head_q <= head_inc;
							occ_q  <= occ_q - OW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the item and accumulate compare results
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
			dup_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (rd_v_s1) begin
			dup_q <= dup_q | flags.dup;
			if (flags.hit) begin
				cnt_q <= cnt_q + OW'(1);
			end
			pkt_q <= rdata;
		end
	end

	// Build the result
	assign cnt_ext   = CW'(cnt_q);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res = '0;
		case (item_q.command)
			dpf_pkg::CMD_ADD: begin
				res.accepted = !dup_q;
			end
			dpf_pkg::CMD_FWD: begin
				if (occ_q != '0) begin
					res.packet_valid    = 1'b1;
					res.out_source      = pkt_q.src;
					res.out_destination = pkt_q.dst;
					res.out_time        = pkt_q.tstamp;
				end
			end
			dpf_pkg::CMD_COUNT: begin
				res.match_count = (cnt_ext > CW'(dpf_pkg::COUNT_MAX)) ? dpf_pkg::COUNT_MAX
				                                                      : cnt_ext[6:0];
			end
			default: begin
				res = '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("occupancy above depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= n_q)
		else $error("scan index past scan length");

	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q == ST_SCAN)
		else $error("read data returned outside scan");

	a_add_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && add_ok && at_limit) |=> occ_q == $past(occ_q))
		else $error("queue grew past its limit");

	a_fwd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.packet_valid) |-> (occ_q != '0 && n_q == OW'(1)))
		else $error("packet forwarded from empty queue");
`endif

endmodule

>>> dv/tb_dedup_packet_fifo_range_count.sv
// ============================================================================
// tb_dedup_packet_fifo_range_count: self-checking bench for the packet FIFO
// Drives command items over the slave stream with bursty gaps, stalls the
// result stream on its own pattern, and checks every result against a
// queue-based model of the bounded, deduplicating packet FIFO.
// ============================================================================
`timescale 1ns / 1ps

module tb_dedup_packet_fifo_range_count;

	import dpf_pkg::*;

	localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES = 90;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT = 10;

	// Command code the block does not decode
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// Result stream stall modes
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// source_id, destination_id, arrival_time, range_start, range_end
	logic [127:0] s_axis_tdata;
	// command
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// out_source, out_destination, out_time, match_count, one zero pad bit
	logic [71:0]  m_axis_tdata;
	// accepted, packet_valid
	logic [1:0]   m_axis_tuser;
	logic         cfg_wr_en;
	logic [6:0]   cfg_wr_data;

	// Model state: queued packets oldest first, and the limit register
	entry_t      queued_packets[$];
	logic [6:0]  limit_shadow;
	logic [31:0] time_cursor;

	// Results still owed by the block, oldest first
	res_t        owed_results[$];

	int          mismatch_count;
	int          result_index;
	int          burst_left;
	bit          valid_up;
	int          quiet_cycles;
	rx_mode_t    rx_mode;
	int          rx_phase_left;
	int          rx_tick;

	dedup_packet_fifo_range_count #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Apply one command to the model and return the result it owes
	function automatic res_t fifo_model_step(item_t it);
		res_t   r;
		entry_t pkt;
		bit     dup;
		int     lim;
		int     n;
		r = '0;
		pkt.src = it.source_id;
		pkt.dst = it.destination_id;
		pkt.tstamp = it.arrival_time;
		case (it.command)
			CMD_ADD: begin
				dup = 1'b0;
				foreach (queued_packets[k])
					if (queued_packets[k] == pkt)
						dup = 1'b1;
				if (!dup) begin
					lim = (limit_shadow == 0) ? 1 :
						(limit_shadow > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_shadow);
					// drop only the single oldest packet when at the limit
					if (queued_packets.size() >= lim)
						void'(queued_packets.pop_front());
					queued_packets.insert(queued_packets.size(), pkt);
					r.accepted = 1'b1;
				end
			end
			CMD_FWD: begin
				if (queued_packets.size() != 0) begin
					pkt = queued_packets.pop_front();
					r.packet_valid = 1'b1;
					r.out_source = pkt.src;
					r.out_destination = pkt.dst;
					r.out_time = pkt.tstamp;
				end
			end
			CMD_COUNT: begin
				n = 0;
				foreach (queued_packets[k])
					if (queued_packets[k].dst == it.destination_id &&
							queued_packets[k].tstamp >= it.range_start &&
							queued_packets[k].tstamp <= it.range_end)
						n++;
				r.match_count = (n > COUNT_MAX) ? COUNT_MAX : n[6:0];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] cmd, logic [15:0] src, logic [15:0] dst,
			logic [31:0] tstamp, logic [31:0] lo, logic [31:0] hi);
		item_t it;
		it.command = cmd;
		it.source_id = src;
		it.destination_id = dst;
		it.arrival_time = tstamp;
		it.range_start = lo;
		it.range_end = hi;
		return it;
	endfunction

	// Build one random command, mostly well-formed traffic around the queue contents
	function automatic item_t make_traffic_item(int add_w, int fwd_w, int cnt_w);
		item_t       it;
		entry_t      pick;
		int          roll;
		int          total;
		logic [31:0] base;
		it.source_id = $urandom;
		it.destination_id = $urandom;
		it.arrival_time = $urandom;
		it.range_start = $urandom;
		it.range_end = $urandom;
		total = add_w + fwd_w + cnt_w;
		roll = $urandom_range(0, total);
		if (roll == total) begin
			it.command = CMD_UNKNOWN;
		end else if (roll < add_w) begin
			it.command = CMD_ADD;
			if (queued_packets.size() != 0 && $urandom_range(0, 4) == 0) begin
				// repeat a queued triple to hit the duplicate check
				pick = queued_packets[$urandom_range(0, queued_packets.size() - 1)];
				it.source_id = pick.src;
				it.destination_id = pick.dst;
				it.arrival_time = pick.tstamp;
			end else begin
				if ($urandom_range(0, 2) != 0)
					it.source_id = $urandom_range(0, 7);
				if ($urandom_range(0, 2) != 0)
					it.destination_id = $urandom_range(0, 3);
				if ($urandom_range(0, 49) != 0) begin
					time_cursor = time_cursor + $urandom_range(0, 2);
					it.arrival_time = time_cursor;
				end
			end
		end else if (roll < add_w + fwd_w) begin
			it.command = CMD_FWD;
		end else begin
			it.command = CMD_COUNT;
			base = time_cursor;
			if (queued_packets.size() != 0 && $urandom_range(0, 1) == 0) begin
				pick = queued_packets[$urandom_range(0, queued_packets.size() - 1)];
				base = pick.tstamp;
				if ($urandom_range(0, 1) == 0)
					it.destination_id = pick.dst;
			end
			if ($urandom_range(0, 4) != 0 && it.destination_id > 16'd3)
				it.destination_id = $urandom_range(0, 3);
			case ($urandom_range(0, 9))
				0: begin
					it.range_start = '0;
					it.range_end = '1;
				end
				1: begin
					// inverted window
					it.range_start = base + $urandom_range(1, 20);
					it.range_end = base;
				end
				2: begin
				end
				default: begin
					it.range_start = base - $urandom_range(0, 3);
					it.range_end = it.range_start + $urandom_range(0, 12);
				end
			endcase
		end
		return it;
	endfunction

	// Send one item, log its expected result, then maybe open a gap
	task automatic send_item(item_t it);
		s_axis_tvalid <= 1'b1;
		valid_up = 1'b1;
		s_axis_tdata <= {it.range_end, it.range_start, it.arrival_time,
			it.destination_id, it.source_id};
		s_axis_tuser <= it.command;
		do
			@(posedge clk);
		while (!s_axis_tready);
		owed_results.insert(owed_results.size(), fifo_model_step(it));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) :
				$urandom_range(0, 8);
		end
	endtask

	// Hold the sender until every owed result has come back
	task automatic drain_results();
		if (valid_up) begin
			s_axis_tvalid <= 1'b0;
			valid_up = 1'b0;
		end
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_queue_limit(logic [6:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_shadow = value;
	endtask

	task automatic run_traffic(int n_items, int add_w, int fwd_w, int cnt_w);
		time_cursor = $urandom;
		repeat (n_items) send_item(make_traffic_item(add_w, fwd_w, cnt_w));
	endtask

	task automatic test_empty_queue();
		send_item(make_item(CMD_FWD, '1, '1, '1, '1, '1));
		send_item(make_item(CMD_COUNT, '0, '0, '0, '0, '1));
		send_item(make_item(CMD_UNKNOWN, '1, '1, '1, '1, '1));
	endtask

	task automatic test_field_extremes();
		send_item(make_item(CMD_ADD, '0, '0, '0, '0, '0));
		send_item(make_item(CMD_ADD, '1, '1, '1, '0, '0));
		send_item(make_item(CMD_ADD, '1, '1, '1, '1, '1));
		send_item(make_item(CMD_COUNT, '0, '1, '0, '0, '1));
		// window with start above end
		send_item(make_item(CMD_COUNT, '0, '0, '0, '1, '0));
		send_item(make_item(CMD_FWD, '0, '0, '0, '0, '0));
		send_item(make_item(CMD_FWD, '0, '0, '0, '0, '0));
	endtask

	task automatic test_out_of_order_times();
		send_item(make_item(CMD_ADD, 16'd1, 16'd7, 32'd100, '0, '0));
		send_item(make_item(CMD_ADD, 16'd2, 16'd7, 32'd50, '0, '0));
		send_item(make_item(CMD_ADD, 16'd3, 16'd7, 32'd75, '0, '0));
		send_item(make_item(CMD_COUNT, '0, 16'd7, '0, 32'd60, 32'd100));
		send_item(make_item(CMD_FWD, '0, '0, '0, '0, '0));
		drain_results();
	endtask

	task automatic test_limit_handling();
		// a limit of zero behaves as one
		set_queue_limit(7'd0);
		send_item(make_item(CMD_ADD, 16'd10, 16'd1, 32'd200, '0, '0));
		send_item(make_item(CMD_ADD, 16'd11, 16'd1, 32'd201, '0, '0));
		send_item(make_item(CMD_FWD, '0, '0, '0, '0, '0));
		drain_results();
		set_queue_limit(7'd64);
		send_item(make_item(CMD_ADD, 16'd20, 16'd2, 32'd300, '0, '0));
		send_item(make_item(CMD_ADD, 16'd21, 16'd2, 32'd301, '0, '0));
		send_item(make_item(CMD_ADD, 16'd22, 16'd2, 32'd302, '0, '0));
		send_item(make_item(CMD_ADD, 16'd23, 16'd2, 32'd303, '0, '0));
		drain_results();
		// lowered below occupancy: an add drops one and keeps the count level
		set_queue_limit(7'd2);
		send_item(make_item(CMD_ADD, 16'd24, 16'd2, 32'd304, '0, '0));
		send_item(make_item(CMD_COUNT, '0, 16'd2, '0, '0, '1));
		drain_results();
	endtask

	task automatic test_full_queue_dedup();
		// above the depth the limit saturates
		set_queue_limit(7'd127);
		run_traffic(300, 70, 8, 22);
		drain_results();
	endtask

	task automatic test_single_slot();
		set_queue_limit(7'd1);
		run_traffic(150, 45, 25, 30);
		drain_results();
	endtask

	task automatic test_small_limits();
		set_queue_limit($urandom_range(2, 10));
		run_traffic(250, 40, 25, 35);
		drain_results();
	endtask

	task automatic test_limit_lowered();
		set_queue_limit(7'd40);
		run_traffic(200, 65, 10, 25);
		drain_results();
		set_queue_limit($urandom_range(3, 8));
		run_traffic(150, 40, 25, 35);
		drain_results();
	endtask

	task automatic test_mixed_traffic();
		set_queue_limit(7'd64);
		run_traffic(375, 45, 25, 30);
		drain_results();
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					result_index, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest owed one
	always @(posedge clk) begin : result_check
		res_t want;
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.out_source = m_axis_tdata[15:0];
			got.out_destination = m_axis_tdata[31:16];
			got.out_time = m_axis_tdata[63:32];
			got.match_count = m_axis_tdata[70:64];
			got.accepted = m_axis_tuser[0];
			got.packet_valid = m_axis_tuser[1];
			if (owed_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result %0d: no result was owed", result_index);
			end else begin
				want = owed_results.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("packet_valid", want.packet_valid, got.packet_valid);
				check_field("out_source", want.out_source, got.out_source);
				check_field("out_destination", want.out_destination, got.out_destination);
				check_field("out_time", want.out_time, got.out_time);
				check_field("match_count", want.match_count, got.match_count);
			end
			result_index++;
		end
	end

	// Stall the result stream: open, random and periodic stretches
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_phase_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_phase_left <= $urandom_range(50, 300);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= (rx_tick % 7) >= 4;
		endcase
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		limit_shadow = LIMIT_RESET;
		time_cursor = '0;
		mismatch_count = 0;
		result_index = 0;
		burst_left = 0;
		valid_up = 1'b0;
		quiet_cycles = 0;
		rx_mode = RX_OPEN;
		rx_phase_left = 0;
		rx_tick = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_field_extremes();
		test_out_of_order_times();
		test_limit_handling();
		test_full_queue_dedup();
		test_single_slot();
		test_small_limits();
		test_limit_lowered();
		test_mixed_traffic();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
